>>> design/gregorian_date_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the Gregorian date unit
// Clocked on clk, held off while rst is high.
// ---------------------------------------------------------------------------
`ifndef GREGORIAN_DATE_UNIT_ASSERT_SVH
`define GREGORIAN_DATE_UNIT_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define GDU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define GDU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/gdu_pkg.sv
// ---------------------------------------------------------------------------
// gdu_pkg
// Types, op codes and calendar tables shared by the Gregorian date unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package gdu_pkg;

  localparam int unsigned MAX_YEAR_DEF = 9999;

  localparam logic [2:0] OP_CHECK    = 3'd0;
  localparam logic [2:0] OP_NEXT     = 3'd1;
  localparam logic [2:0] OP_PREV     = 3'd2;
  localparam logic [2:0] OP_WEEK     = 3'd3;
  localparam logic [2:0] OP_DURATION = 3'd4;
  localparam logic [2:0] OP_BIRTHDAY = 3'd5;

  typedef struct packed {
    logic [2:0]  op;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [4:0]  other_day;
    logic [3:0]  other_month;
    logic [13:0] other_year;
  } query_t;

  typedef struct packed {
    logic        date_ok;
    logic        leap_year;
    logic [4:0]  out_day;
    logic [3:0]  out_month;
    logic [13:0] out_year;
    logic [21:0] count;
  } result_t;

  // per-date facts derived from day, month and year
  typedef struct packed {
    logic        leap;
    logic        ok;
    logic [8:0]  doy;    // 1-based day of year
    logic [12:0] leaps;  // leap years strictly before the year
  } date_info_t;

  // year / 100 by reciprocal multiply, exact for any 14-bit year
  function automatic logic [7:0] div100(input logic [13:0] y);
    logic [27:0] p;
    p = 28'(y) * 28'd10486;
    return p[27:20];
  endfunction

  function automatic logic [8:0] cum_days(input logic [3:0] m);
    case (m)
      4'd2:    return 9'd31;
      4'd3:    return 9'd59;
      4'd4:    return 9'd90;
      4'd5:    return 9'd120;
      4'd6:    return 9'd151;
      4'd7:    return 9'd181;
      4'd8:    return 9'd212;
      4'd9:    return 9'd243;
      4'd10:   return 9'd273;
      4'd11:   return 9'd304;
      4'd12:   return 9'd334;
      default: return 9'd0;
    endcase
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    return 5'd30;
      4'd2:    return leap ? 5'd29 : 5'd28;
      default: return 5'd0;
    endcase
  endfunction

endpackage

>>> design/gdu_date_info.sv
// ---------------------------------------------------------------------------
// gdu_date_info
// Leap flag, validity, day of year and prior leap-year count for one date,
// given the year and its precomputed quotient by 100.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module gdu_date_info import gdu_pkg::*; #(
  parameter int unsigned MAX_YEAR = MAX_YEAR_DEF
) (
  input  logic [4:0]  day,
  input  logic [3:0]  month,
  input  logic [13:0] year,
  input  logic [7:0]  cent,
  output date_info_t  info
);

  logic [13:0] hund;
  logic        cent_even;
  logic        leap;
  logic [4:0]  mlen;
  logic [12:0] quads;
  logic [8:0]  cents;
  logic [6:0]  quads400;

  assign hund      = 14'(cent) * 14'd100;
  assign cent_even = (year == hund);
  // divisible by 400 when divisible by 100 and the quotient by 4
  assign leap      = (year[1:0] == 2'd0 && !cent_even) || (cent_even && cent[1:0] == 2'd0);
  assign mlen      = month_len(month, leap);

  // ceil(y/4) - ceil(y/100) + ceil(y/400)
  assign quads    = 13'((15'(year) + 15'd3) >> 2);
  assign cents    = 9'(cent) + 9'(!cent_even);
  assign quads400 = 7'((10'(cents) + 10'd3) >> 2);

  always_comb begin
    info.leap  = leap;
    info.ok    = (month >= 4'd1) && (month <= 4'd12) && (year <= 14'(MAX_YEAR)) &&
                 (day >= 5'd1) && (day <= mlen);
    info.doy   = cum_days(month) + 9'(day) + 9'(month > 4'd2 && leap);
    info.leaps = quads - 13'(cents) + 13'(quads400);
  end

endmodule

>>> design/gregorian_date_unit.sv
// ---------------------------------------------------------------------------
// gregorian_date_unit
// Pipelined Gregorian date unit: validity, next and previous day, week
// number, day difference and days to birthday for years 0 to MAX_YEAR.
// ---------------------------------------------------------------------------
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------
//  query    | query_valid / query_stall  | query  (query_t)
//  result   | result_valid / result_stall| result (result_t)
//
// Four register stages: quotient by 100, date facts, serials and next or
// previous date, final select. A query beat passes through them in that
// order; one beat is taken every cycle unless a stalled result has filled the stages.
// Each stage advances when its successor is empty or moving, so bubbles
// close up and a stalled result only holds the stages behind it once full.
// rst clears the valid bits only; data registers load freely.
`timescale 1ns / 1ps

module gregorian_date_unit import gdu_pkg::*; #(
  parameter int unsigned MAX_YEAR = MAX_YEAR_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    query_valid,
  output logic    query_stall,
  input  query_t  query,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  typedef struct packed {
    logic [2:0]  op;
    logic        leap;
    logic        main_ok;
    logic        oth_ok;
    logic        bday_ok;
    logic [22:0] ser_m;
    logic [22:0] ser_o;
    logic [8:0]  doy_m;
    logic [8:0]  doy_b;
    logic        bday_past;
    logic        early;
    logic [4:0]  nxt_d;
    logic [3:0]  nxt_m;
    logic [13:0] nxt_y;
    logic [4:0]  prv_d;
    logic [3:0]  prv_m;
    logic [13:0] prv_y;
    logic [5:0]  week;
  } mid_t;

  // pipeline flow control
  logic s1_valid, s2_valid, s3_valid;
  logic s1_ready, s2_ready, s3_ready, out_ready;

  assign out_ready   = !result_valid || !result_stall;
  assign s3_ready    = !s3_valid || out_ready;
  assign s2_ready    = !s2_valid || s3_ready;
  assign s1_ready    = !s1_valid || s2_ready;
  assign query_stall = !s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      s3_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (s1_ready)  s1_valid     <= query_valid;
      if (s2_ready)  s2_valid     <= s1_valid;
      if (s3_ready)  s3_valid     <= s2_valid;
      if (out_ready) result_valid <= s3_valid;
    end
  end

  // stage 1: quotients by 100
  query_t     s1_q;
  logic [7:0] s1_cent_y, s1_cent_o;

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_q      <= query;
      s1_cent_y <= div100(query.year);
      s1_cent_o <= div100(query.other_year);
    end
  end

  // stage 2: per-date facts
  date_info_t info_m, info_o, info_b;
  query_t     s2_q;
  date_info_t s2_m, s2_o, s2_b;

  gdu_date_info #(.MAX_YEAR(MAX_YEAR)) u_main (
    .day(s1_q.day), .month(s1_q.month), .year(s1_q.year), .cent(s1_cent_y), .info(info_m)
  );

  gdu_date_info #(.MAX_YEAR(MAX_YEAR)) u_other (
    .day(s1_q.other_day), .month(s1_q.other_month), .year(s1_q.other_year),
    .cent(s1_cent_o), .info(info_o)
  );

  // birthday placed in the main year
  gdu_date_info #(.MAX_YEAR(MAX_YEAR)) u_bday (
    .day(s1_q.other_day), .month(s1_q.other_month), .year(s1_q.year),
    .cent(s1_cent_y), .info(info_b)
  );

  always_ff @(posedge clk) begin
    if (s2_ready) begin
      s2_q <= s1_q;
      s2_m <= info_m;
      s2_o <= info_o;
      s2_b <= info_b;
    end
  end

  // stage 3: serials, neighbor dates, week
  mid_t        mid_next;
  mid_t        s3;
  logic [4:0]  mlen;
  logic [17:0] week_prod;

  always_comb begin
    mid_next.op      = s2_q.op;
    mid_next.leap    = s2_m.leap;
    mid_next.main_ok = s2_m.ok;
    mid_next.oth_ok  = s2_o.ok;
    mid_next.bday_ok = s2_b.ok;
    mid_next.ser_m   = 23'(s2_q.year) * 23'd365 + 23'(s2_m.leaps) + 23'(s2_m.doy) - 23'd1;
    mid_next.ser_o   = 23'(s2_q.other_year) * 23'd365 + 23'(s2_o.leaps) +
                       23'(s2_o.doy) - 23'd1;
    mid_next.doy_m   = s2_m.doy;
    mid_next.doy_b   = s2_b.doy;
    mid_next.bday_past = (s2_q.other_month < s2_q.month) ||
                         (s2_q.other_month == s2_q.month && s2_q.other_day < s2_q.day);
    mid_next.early   = (s2_q.month < 4'd2 || (s2_q.month == 4'd2 && s2_q.day < 5'd29)) &&
                       s2_m.leap;

    // next day
    mlen = month_len(s2_q.month, s2_m.leap);
    mid_next.nxt_d = s2_q.day + 5'd1;
    mid_next.nxt_m = s2_q.month;
    mid_next.nxt_y = s2_q.year;
    if (s2_q.day == mlen) begin
      mid_next.nxt_d = 5'd1;
      if (s2_q.month == 4'd12) begin
        mid_next.nxt_m = 4'd1;
        mid_next.nxt_y = (s2_q.year >= 14'(MAX_YEAR)) ? 14'd0 : s2_q.year + 14'd1;
      end else begin
        mid_next.nxt_m = s2_q.month + 4'd1;
      end
    end

    // previous day
    mid_next.prv_d = s2_q.day - 5'd1;
    mid_next.prv_m = s2_q.month;
    mid_next.prv_y = s2_q.year;
    if (s2_q.day <= 5'd1) begin
      if (s2_q.month > 4'd1) begin
        mid_next.prv_m = s2_q.month - 4'd1;
        mid_next.prv_d = month_len(s2_q.month - 4'd1, s2_m.leap);
      end else begin
        mid_next.prv_m = 4'd12;
        mid_next.prv_d = 5'd31;
        mid_next.prv_y = (s2_q.year == 14'd0) ? 14'(MAX_YEAR) : s2_q.year - 14'd1;
      end
    end

    // doy / 7 via 293 / 2048, exact up to 366
    week_prod     = 18'(s2_m.doy) * 18'd293;
    mid_next.week = 6'(week_prod[17:11]) + 6'd1;
  end

  always_ff @(posedge clk) begin
    if (s3_ready) begin
      s3 <= mid_next;
    end
  end

  // stage 4: differences and final select
  result_t     res_next;
  logic        ok;
  logic [22:0] ser_diff;
  logic [8:0]  dur;
  logic [9:0]  bcnt;

  always_comb begin
    ser_diff = (s3.ser_m > s3.ser_o) ? s3.ser_m - s3.ser_o : s3.ser_o - s3.ser_m;
    dur      = (s3.doy_m > s3.doy_b) ? s3.doy_m - s3.doy_b : s3.doy_b - s3.doy_m;
    bcnt     = s3.bday_past ? 10'd366 - 10'(dur) + 10'(s3.early) : 10'(dur);

    case (s3.op)
      OP_CHECK, OP_NEXT, OP_PREV, OP_WEEK: ok = s3.main_ok;
      OP_DURATION: ok = s3.main_ok && s3.oth_ok;
      OP_BIRTHDAY: ok = s3.main_ok && s3.bday_ok;
      default:     ok = 1'b0;
    endcase

    res_next.date_ok   = ok;
    res_next.leap_year = s3.leap;
    res_next.out_day   = '0;
    res_next.out_month = '0;
    res_next.out_year  = '0;
    res_next.count     = '0;
    if (ok) begin
      case (s3.op)
        OP_NEXT: begin
          res_next.out_day   = s3.nxt_d;
          res_next.out_month = s3.nxt_m;
          res_next.out_year  = s3.nxt_y;
        end
        OP_PREV: begin
          res_next.out_day   = s3.prv_d;
          res_next.out_month = s3.prv_m;
          res_next.out_year  = s3.prv_y;
        end
        OP_WEEK:     res_next.count = 22'(s3.week);
        OP_DURATION: res_next.count = ser_diff[21:0];
        OP_BIRTHDAY: res_next.count = 22'(bcnt);
        default:     res_next.count = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready) begin
      result <= res_next;
    end
  end

  // result beat shapes watched by the assertions
  logic res_failed, res_blank, res_dated, res_date_form;

  assign res_failed    = result_valid && !result.date_ok;
  assign res_blank     = (result.out_day == 5'd0) && (result.out_month == 4'd0) &&
                         (result.out_year == 14'd0) && (result.count == 22'd0);
  assign res_dated     = result_valid && (result.out_month != 4'd0);
  assign res_date_form = result.date_ok && (result.out_day != 5'd0) &&
                         (result.count == 22'd0);

  `include "gregorian_date_unit_assert.svh"

  `GDU_ASSERT_NEXT(a_beat_enters, query_valid && !query_stall, s1_valid, "query beat lost")
  `GDU_ASSERT_NEXT(a_s3_holds, s3_valid && !s3_ready, s3_valid, "stalled item dropped")
  `GDU_ASSERT_NOW(a_bad_zero, res_failed, res_blank, "error result not zeroed")
  `GDU_ASSERT_NOW(a_date_xor_count, res_dated, res_date_form, "date result malformed")

endmodule

>>> tb/sv/gdu_date_checker.sv
// ---------------------------------------------------------------------------
// gdu_date_checker
// Watches both channels of the Gregorian date unit. Each accepted query beat
// is turned into its expected result, and each accepted result beat is
// compared field by field with the oldest expected result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module gdu_date_checker import gdu_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    query_valid,
  input  logic    query_stall,
  input  query_t  query,
  input  logic    result_valid,
  input  logic    result_stall,
  input  result_t result,
  output int      errors,
  output int      pending
);

  localparam int unsigned LAST_YEAR = MAX_YEAR_DEF;
  localparam int          SHOWN     = 10;

  result_t     expected_results[$];
  int unsigned results_seen;

  function automatic bit leap_of(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned days_in(input int unsigned m, input int unsigned y);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return leap_of(y) ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  function automatic bit date_valid(input int unsigned d, input int unsigned m,
                                    input int unsigned y);
    return (y <= LAST_YEAR) && (d >= 1) && (d <= days_in(m, y));
  endfunction

  // 1-based position of a valid date within its year
  function automatic int unsigned ordinal_day(input int unsigned d, input int unsigned m,
                                              input int unsigned y);
    int unsigned n;
    n = d;
    for (int unsigned k = 1; k < m; k++) n += days_in(k, y);
    return n;
  endfunction

  // days elapsed since 0000-01-01
  function automatic int unsigned day_number(input int unsigned d, input int unsigned m,
                                             input int unsigned y);
    int unsigned leaps_before;
    leaps_before = (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
    return 365 * y + leaps_before + ordinal_day(d, m, y) - 1;
  endfunction

  function automatic result_t expected_date_result(input query_t q);
    result_t     r;
    int unsigned d, m, y, od, om, oy;
    int unsigned a, b, cnt;
    bit          ok, main_ok;
    d  = q.day;
    m  = q.month;
    y  = q.year;
    od = q.other_day;
    om = q.other_month;
    oy = q.other_year;
    r = '0;
    cnt = 0;
    ok = 1'b0;
    main_ok = date_valid(d, m, y);
    r.leap_year = leap_of(y);
    case (q.op)
      OP_CHECK: ok = main_ok;
      OP_NEXT: begin
        ok = main_ok;
        if (d < days_in(m, y)) begin
          r.out_day   = 5'(d + 1);
          r.out_month = 4'(m);
          r.out_year  = 14'(y);
        end else if (m < 12) begin
          r.out_day   = 5'd1;
          r.out_month = 4'(m + 1);
          r.out_year  = 14'(y);
        end else begin
          r.out_day   = 5'd1;
          r.out_month = 4'd1;
          r.out_year  = (y >= LAST_YEAR) ? 14'd0 : 14'(y + 1);
        end
      end
      OP_PREV: begin
        ok = main_ok;
        if (d > 1) begin
          r.out_day   = 5'(d - 1);
          r.out_month = 4'(m);
          r.out_year  = 14'(y);
        end else if (m > 1) begin
          r.out_day   = 5'(days_in(m - 1, y));
          r.out_month = 4'(m - 1);
          r.out_year  = 14'(y);
        end else begin
          r.out_day   = 5'd31;
          r.out_month = 4'd12;
          r.out_year  = (y == 0) ? 14'(LAST_YEAR) : 14'(y - 1);
        end
      end
      OP_WEEK: begin
        ok = main_ok;
        if (ok) cnt = ordinal_day(d, m, y) / 7 + 1;
      end
      OP_DURATION: begin
        ok = main_ok && date_valid(od, om, oy);
        if (ok) begin
          a = day_number(d, m, y);
          b = day_number(od, om, oy);
          cnt = (a > b) ? a - b : b - a;
        end
      end
      OP_BIRTHDAY: begin
        // the birthday is placed in the main year
        ok = main_ok && date_valid(od, om, y);
        if (ok) begin
          a = ordinal_day(d, m, y);
          b = ordinal_day(od, om, y);
          cnt = (a > b) ? a - b : b - a;
          if (om < m || (om == m && od < d)) begin
            cnt = 366 - cnt;
            if ((m < 2 || (m == 2 && d < 29)) && leap_of(y)) cnt += 1;
          end
        end
      end
      default: ok = 1'b0;
    endcase
    r.date_ok = ok;
    r.count   = 22'(cnt);
    if (!ok) begin
      r.out_day   = '0;
      r.out_month = '0;
      r.out_year  = '0;
      r.count     = '0;
    end
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned exp_val,
                             input int unsigned act_val);
    if (exp_val != act_val) begin
      errors++;
      if (errors <= SHOWN)
        $display("result beat %0d: %s expected %0d, got %0d",
                 results_seen, name, exp_val, act_val);
    end
  endtask

  always @(posedge clk) begin
    result_t exp_r;
    if (rst) begin
      expected_results.delete();
      errors = 0;
      results_seen = 0;
    end else begin
      // retire results before queuing new queries
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= SHOWN)
            $display("result beat %0d: none expected, got %p", results_seen, result);
        end else begin
          exp_r = expected_results.pop_front();
          check_field("date_ok",   exp_r.date_ok,   result.date_ok);
          check_field("leap_year", exp_r.leap_year, result.leap_year);
          check_field("out_day",   exp_r.out_day,   result.out_day);
          check_field("out_month", exp_r.out_month, result.out_month);
          check_field("out_year",  exp_r.out_year,  result.out_year);
          check_field("count",     exp_r.count,     result.count);
        end
        results_seen++;
      end
      if (query_valid && !query_stall)
        expected_results.push_back(expected_date_result(query));
    end
    pending = expected_results.size();
  end

endmodule

>>> tb/sv/tb_gregorian_date_unit.sv
// ---------------------------------------------------------------------------
// tb_gregorian_date_unit
// Drives directed and random date queries into the Gregorian date unit with
// random gaps on the query side and random stalls on the result side; the
// checker beside the unit predicts and compares every result beat.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_gregorian_date_unit;
  import gdu_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int          RANDOM_ITEMS = 625;
  localparam int          CALM_ITEMS   = 100;
  localparam int          LONG_HOLD    = 90;
  localparam int          HOLD_ROUND   = 12;
  localparam logic [2:0]  OP_RSVD6     = 3'd6;
  localparam logic [2:0]  OP_RSVD7     = 3'd7;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        query_valid = 1'b0;
  logic        result_stall = 1'b0;
  query_t      query = '0;
  logic        query_stall;
  logic        result_valid;
  result_t     result;
  int          errors;
  int          pending;
  bit          calm = 1'b0;
  int unsigned cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  gregorian_date_unit dut (
    .clk          (clk),
    .rst          (rst),
    .query_valid  (query_valid),
    .query_stall  (query_stall),
    .query        (query),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  gdu_date_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .query_valid  (query_valid),
    .query_stall  (query_stall),
    .query        (query),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .errors       (errors),
    .pending      (pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic query_t date_query(input logic [2:0] op, input logic [4:0] d,
                                        input logic [3:0] m, input logic [13:0] y,
                                        input logic [4:0] od, input logic [3:0] om,
                                        input logic [13:0] oy);
    query_t q;
    q.op          = op;
    q.day         = d;
    q.month       = m;
    q.year        = y;
    q.other_day   = od;
    q.other_month = om;
    q.other_year  = oy;
    return q;
  endfunction

  // well-formed date biased toward month ends, year ends and century years;
  // 29 Feb is offered in every year, so common years get a few invalid ones
  function automatic void pick_date(output logic [4:0] d, output logic [3:0] m,
                                    output logic [13:0] y);
    case ($urandom_range(0, 5))
      0:       y = 14'd0;
      1:       y = 14'(MAX_YEAR_DEF);
      2:       y = 14'(100 * $urandom_range(0, 99));
      default: y = 14'($urandom_range(0, MAX_YEAR_DEF));
    endcase
    m = 4'($urandom_range(1, 12));
    case ($urandom_range(0, 3))
      0: d = 5'd1;
      1: begin
        case (m)
          4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
          4'd2:                    d = 5'($urandom_range(28, 29));
          default:                 d = 5'd31;
        endcase
      end
      default: d = 5'($urandom_range(1, 28));
    endcase
  endfunction

  function automatic query_t random_query();
    query_t      q;
    logic [63:0] raw;
    if ($urandom_range(0, 39) == 0)
      q.op = $urandom_range(0, 1) ? OP_RSVD6 : OP_RSVD7;
    else
      q.op = 3'($urandom_range(OP_CHECK, OP_BIRTHDAY));
    if ($urandom_range(0, 9) == 0) begin
      // raw bits: out-of-range days, months and years
      raw = {$urandom(), $urandom()};
      q.day         = raw[4:0];
      q.month       = raw[8:5];
      q.year        = raw[22:9];
      q.other_day   = raw[27:23];
      q.other_month = raw[31:28];
      q.other_year  = raw[45:32];
    end else begin
      pick_date(q.day, q.month, q.year);
      pick_date(q.other_day, q.other_month, q.other_year);
      case ($urandom_range(0, 19))
        0: begin
          q.day = 5'd31; q.month = 4'd12; q.year = 14'(MAX_YEAR_DEF);
        end
        1: begin
          q.day = 5'd1; q.month = 4'd1; q.year = 14'd0;
        end
        2, 3: begin
          q.other_day = 5'd29; q.other_month = 4'd2;
        end
        4: q.other_month = 4'($urandom_range(13, 15));
        5: q.other_year = 14'($urandom_range(MAX_YEAR_DEF + 1, 16383));
        default: ;
      endcase
    end
    return q;
  endfunction

  task automatic offer_query(input query_t q);
    if (!calm && $urandom_range(0, 4) == 0) begin
      query_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    query_valid <= 1'b1;
    query <= q;
    @(posedge clk);
    while (query_stall) @(posedge clk);
  endtask

  // result side: short stall bursts, one long hold-off to back up the pipeline
  initial begin : result_side
    int unsigned rounds;
    rounds = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      rounds++;
      if (rounds == HOLD_ROUND) begin
        result_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        result_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, 2) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        result_stall <= 1'b0;
      end
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  initial begin : query_side
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // validity, including field extremes and century leap rules
    offer_query(date_query(OP_CHECK, 5'd1, 4'd1, 14'd0, 5'd0, 4'd0, 14'd0));
    offer_query(date_query(OP_CHECK, 5'd31, 4'd15, 14'd16383, 5'd31, 4'd15, 14'd16383));
    offer_query(date_query(OP_CHECK, 5'd0, 4'd12, 14'd2000, 5'd1, 4'd1, 14'd1));
    offer_query(date_query(OP_CHECK, 5'd29, 4'd2, 14'd1900, 5'd1, 4'd1, 14'd1));
    offer_query(date_query(OP_CHECK, 5'd29, 4'd2, 14'd2000, 5'd1, 4'd1, 14'd1));
    // next day: wrap of the last year, month ends, out-of-range year
    offer_query(date_query(OP_NEXT, 5'd31, 4'd12, 14'd9999, 5'd0, 4'd0, 14'd0));
    offer_query(date_query(OP_NEXT, 5'd28, 4'd2, 14'd2023, 5'd0, 4'd0, 14'd0));
    offer_query(date_query(OP_NEXT, 5'd29, 4'd2, 14'd2024, 5'd0, 4'd0, 14'd0));
    offer_query(date_query(OP_NEXT, 5'd31, 4'd1, 14'd10000, 5'd0, 4'd0, 14'd0));
    // previous day: wrap of year zero, into February, into a 30-day month
    offer_query(date_query(OP_PREV, 5'd1, 4'd1, 14'd0, 5'd0, 4'd0, 14'd0));
    offer_query(date_query(OP_PREV, 5'd1, 4'd3, 14'd2024, 5'd0, 4'd0, 14'd0));
    offer_query(date_query(OP_PREV, 5'd1, 4'd3, 14'd2100, 5'd0, 4'd0, 14'd0));
    offer_query(date_query(OP_PREV, 5'd1, 4'd5, 14'd2023, 5'd0, 4'd0, 14'd0));
    // week number
    offer_query(date_query(OP_WEEK, 5'd31, 4'd12, 14'd2024, 5'd0, 4'd0, 14'd0));
    offer_query(date_query(OP_WEEK, 5'd1, 4'd1, 14'd2023, 5'd0, 4'd0, 14'd0));
    // duration: full span, zero span, bad second date
    offer_query(date_query(OP_DURATION, 5'd1, 4'd1, 14'd0, 5'd31, 4'd12, 14'd9999));
    offer_query(date_query(OP_DURATION, 5'd15, 4'd6, 14'd2020, 5'd15, 4'd6, 14'd2020));
    offer_query(date_query(OP_DURATION, 5'd15, 4'd6, 14'd2020, 5'd1, 4'd13, 14'd2020));
    // birthday: leap day, invalid leap day, earlier in the year, same day
    offer_query(date_query(OP_BIRTHDAY, 5'd1, 4'd1, 14'd2024, 5'd29, 4'd2, 14'd0));
    offer_query(date_query(OP_BIRTHDAY, 5'd10, 4'd3, 14'd2023, 5'd29, 4'd2, 14'd0));
    offer_query(date_query(OP_BIRTHDAY, 5'd15, 4'd8, 14'd2024, 5'd1, 4'd2, 14'd0));
    offer_query(date_query(OP_BIRTHDAY, 5'd1, 4'd2, 14'd2024, 5'd31, 4'd1, 14'd0));
    offer_query(date_query(OP_BIRTHDAY, 5'd7, 4'd7, 14'd1999, 5'd7, 4'd7, 14'd16383));
    // unused op codes
    offer_query(date_query(OP_RSVD6, 5'd1, 4'd1, 14'd2000, 5'd1, 4'd1, 14'd2000));
    offer_query(date_query(OP_RSVD7, 5'd1, 4'd1, 14'd2000, 5'd1, 4'd1, 14'd2000));

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      // run the tail back to back on both sides
      if (k == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      offer_query(random_query());
    end
    query_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
